// ----- src/ahc_pkg.sv -----
// Shared types, constants and helpers for the anagram histogram checker.
// No dependencies; every other file of the block imports this package.
package ahc_pkg;

    localparam int CHAR_W = 8;
    localparam int NUM_CHARS = 1 << CHAR_W;
    // Nonzero count tracker spans 0..NUM_CHARS
    localparam int NZ_W = $clog2(NUM_CHARS + 1);

    localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'h20;
    localparam logic [CHAR_W-1:0] UPPER_A     = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_Z     = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    // Phrase select codes
    localparam logic PHRASE_FIRST  = 1'b0;
    localparam logic PHRASE_SECOND = 1'b1;

    // Write command into the count store
    typedef struct packed {
        logic              en;
        logic [CHAR_W-1:0] addr;
    } t_cnt_wr;

    // Fold ASCII upper case to lower case, other bytes pass unchanged
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= UPPER_A && c <= UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ----- src/ahc_if.sv -----
// Valid/ready channel interfaces for the anagram histogram checker.
// Depends on ahc_pkg for the character width.
interface ahc_in_if import ahc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ch;
    logic              phrase_sel;
    logic              last;
    logic              ch_valid;

    modport source (output valid, output ch, output phrase_sel, output last,
                    output ch_valid, input ready);
    modport sink   (input valid, input ch, input phrase_sel, input last,
                    input ch_valid, output ready);
endinterface

interface ahc_out_if;
    logic valid;
    logic ready;
    logic is_match;
    logic overflow;

    modport source (output valid, output is_match, output overflow, input ready);
    modport sink   (input valid, input is_match, input overflow, output ready);
endinterface

// ----- src/ahc_count_store.sv -----
// Per-character signed count memory with one valid bit per entry.
// Depends on ahc_pkg (t_cnt_wr, NUM_CHARS, CHAR_W).
module ahc_count_store import ahc_pkg::*; #(
    parameter int CNT_W = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [CHAR_W-1:0] i_rd_addr,
    output logic [CNT_W-1:0]  o_rd_data,
    input  t_cnt_wr           i_wr,
    input  logic [CNT_W-1:0]  i_wr_data,
    input  logic              i_clr
);

    logic [CNT_W-1:0]     r_mem [NUM_CHARS];
    logic [NUM_CHARS-1:0] r_vld;
    logic [CNT_W-1:0]     r_rd_data;
    logic                 r_rd_vld;

    // Count memory write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_vld[i_rd_addr];
        end
    end

    // Valid bits: clear wipes all counts at once, clear wins over a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_clr) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // Entry never written since the last clear reads as zero
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- src/anagram_histogram_check.sv -----
// Anagram checker: per-character histogram, up for phrase one, down for phrase two.
// Result: registered in the result register as the item marked last leaves the update stage.
// Throughput: one character per cycle; the count read-modify-write is split over
// the memory read edge and one update stage, with forwarding between neighbors.
// Input stalls only while a result waits untaken and the next last item sits in
// the update stage. Reset: synchronous active low; 256 valid bits clear all counts.
module anagram_histogram_check import ahc_pkg::*; #(
    parameter int MAX_LEN = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ahc_in_if.sink    i_in,
    ahc_out_if.source o_out
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int CNT_W = LEN_W + 1;
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LEN);

    // Accept side
    logic              in_acc;
    logic [CHAR_W-1:0] in_char;
    logic [LEN_W-1:0]  sel_len;
    logic              want;
    logic              counted;
    logic              new_ovf;

    logic [LEN_W-1:0] r_len1, n_len1;
    logic [LEN_W-1:0] r_len2, n_len2;
    logic             r_ovf, n_ovf;

    // Update stage
    logic              r_s1_v, n_s1_v;
    logic [CHAR_W-1:0] r_s1_addr;
    logic              r_s1_dec;
    logic              r_s1_cnt;
    logic              r_s1_last;
    logic              r_s1_ovf;
    logic              r_s1_fwd;
    logic [CNT_W-1:0]  r_s1_fwd_val;
    logic              r_s1_clr;

    logic             s1_adv;
    logic             s1_wr;
    logic             s1_clr;
    logic [CNT_W-1:0] rd_data;
    logic [CNT_W-1:0] prev_cnt;
    logic [CNT_W-1:0] after;
    logic [NZ_W-1:0]  nz_upd;
    logic [NZ_W-1:0]  r_nz, n_nz;

    // Result register
    logic r_o_v, n_o_v;
    logic r_o_anagram;
    logic r_o_ovf;

    t_cnt_wr wr_cmd;

    // Character filtering and phrase length check
    assign in_acc  = i_in.valid && i_in.ready;
    assign in_char = fold_char(i_in.ch);
    assign sel_len = (i_in.phrase_sel == PHRASE_SECOND) ? r_len2 : r_len1;
    assign want    = i_in.ch_valid && (i_in.ch != SPACE_CHAR);
    assign counted = want && (sel_len < LEN_LIMIT);
    assign new_ovf = want && (sel_len >= LEN_LIMIT);

    // Stage handshake
    assign s1_adv     = r_s1_v && (!r_s1_last || !r_o_v || o_out.ready);
    assign s1_wr      = s1_adv && r_s1_cnt;
    assign s1_clr     = s1_adv && r_s1_last;
    assign i_in.ready = !r_s1_v || s1_adv;

    // Length and overflow tracking, settled at accept
    always_comb begin
        n_len1 = r_len1;
        n_len2 = r_len2;
        n_ovf  = r_ovf;
        if (in_acc) begin
            if (counted && i_in.phrase_sel == PHRASE_FIRST) begin
                n_len1 = r_len1 + LEN_W'(1);
            end
            if (counted && i_in.phrase_sel == PHRASE_SECOND) begin
                n_len2 = r_len2 + LEN_W'(1);
            end
            n_ovf = r_ovf | new_ovf;
            if (i_in.last) begin
                n_len1 = '0;
                n_len2 = '0;
                n_ovf  = 1'b0;
            end
        end
    end

    always_comb begin
        n_s1_v = r_s1_v;
        if (in_acc) begin
            n_s1_v = 1'b1;
        end else if (s1_adv) begin
            n_s1_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len1 <= '0;
            r_len2 <= '0;
            r_ovf  <= 1'b0;
            r_s1_v <= 1'b0;
        end else begin
            r_len1 <= n_len1;
            r_len2 <= n_len2;
            r_ovf  <= n_ovf;
            r_s1_v <= n_s1_v;
        end
    end

    // Stage payload; forward and clear hazards are caught at the read edge
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr    <= in_char;
            r_s1_dec     <= (i_in.phrase_sel == PHRASE_SECOND);
            r_s1_cnt     <= counted;
            r_s1_last    <= i_in.last;
            r_s1_ovf     <= r_ovf | new_ovf;
            r_s1_fwd     <= s1_wr && (r_s1_addr == in_char);
            r_s1_fwd_val <= after;
            r_s1_clr     <= s1_clr;
        end
    end

    // Count store
    assign wr_cmd.en   = s1_wr;
    assign wr_cmd.addr = r_s1_addr;

    ahc_count_store #(
        .CNT_W (CNT_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (in_char),
        .o_rd_data (rd_data),
        .i_wr      (wr_cmd),
        .i_wr_data (after),
        .i_clr     (s1_clr)
    );

    // Count update and nonzero tracking
    always_comb begin
        if (r_s1_clr) begin
            prev_cnt = '0;
        end else if (r_s1_fwd) begin
            prev_cnt = r_s1_fwd_val;
        end else begin
            prev_cnt = rd_data;
        end
        after = r_s1_dec ? (prev_cnt - CNT_W'(1)) : (prev_cnt + CNT_W'(1));

        nz_upd = r_nz;
        if (r_s1_cnt) begin
            if (prev_cnt == '0) begin
                nz_upd = r_nz + NZ_W'(1);
            end else if (after == '0) begin
                nz_upd = r_nz - NZ_W'(1);
            end
        end

        n_nz = r_nz;
        if (s1_adv) begin
            n_nz = r_s1_last ? '0 : nz_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz <= '0;
        end else begin
            r_nz <= n_nz;
        end
    end

    // Result register
    always_comb begin
        n_o_v = r_o_v;
        if (s1_clr) begin
            n_o_v = 1'b1;
        end else if (o_out.ready) begin
            n_o_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= n_o_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_clr) begin
            r_o_anagram <= !r_s1_ovf && (nz_upd == '0);
            r_o_ovf     <= r_s1_ovf;
        end
    end

    assign o_out.valid    = r_o_v;
    assign o_out.is_match = r_o_anagram;
    assign o_out.overflow = r_o_ovf;

    // Checks
    a_nz_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nz <= NZ_W'(NUM_CHARS))
        else $error("nonzero count tracker out of range");

    a_nz_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_clr |=> (r_nz == '0))
        else $error("nonzero tracker not cleared after result");

    a_result_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v |-> !(r_o_anagram && r_o_ovf))
        else $error("overflow result flagged as anagram");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1_v && r_s1_last && r_o_v))
        else $error("input stalled without a waiting result");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len1 <= LEN_LIMIT) && (r_len2 <= LEN_LIMIT))
        else $error("phrase length beyond limit");

endmodule
